[src/lac_pkg.sv]
`default_nettype none

package lac_pkg;

	localparam int MAX_FRAME_WIDTH  = 256;
	localparam int MAX_FRAME_HEIGHT = 256;
	localparam int MAX_SURFACE_SIZE = 1024;

	localparam int STORE_DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int X_W = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
	localparam int Y_W = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
	localparam int FW_W = $clog2(MAX_FRAME_WIDTH + 1);
	localparam int FH_W = $clog2(MAX_FRAME_HEIGHT + 1);

	localparam int CFG_DIM_W   = 9;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int COLOR_W     = 24;
	localparam int SURF_W      = 11;
	localparam int POS_W       = 10;

	localparam logic [7:0] ALPHA_FULL = 8'hFF;

	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND   = 2'd2;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_BLEND = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_LOOKUP,
		S_READ,
		S_MUL,
		S_CLEAR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic signed [15:0] layer_left;
		logic signed [15:0] layer_top;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [SURF_W-1:0] surface_width;
		logic [SURF_W-1:0] surface_height;
		logic signed [15:0] clip_width;
		logic signed [15:0] clip_height;
		logic [31:0]       pixel_rgba;
		logic              opaque;
		logic              layer_visible;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] read_color;
		logic               pixel_drawn;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       clr_last;
		logic       out_free;
	} stat_t;

endpackage

`default_nettype wire

[src/lac_req_if.sv]
`default_nettype none

interface lac_req_if;
	logic          valid;
	logic          ready;
	lac_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/lac_rsp_if.sv]
`default_nettype none

interface lac_rsp_if;
	logic          valid;
	logic          ready;
	lac_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/lac_ctrl.sv]
`default_nettype none

module lac_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire lac_pkg::stat_t stat,
	output lac_pkg::cmd_t       cmd
);
	import lac_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.mode == MODE_CLEAR) begin
					state_d = S_CLEAR;
				end else begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: state_d = S_READ;
			S_READ: state_d = S_MUL;
			S_MUL: state_d = S_FINISH;
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the output register can take the word
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[src/lac_datapath.sv]
`default_nettype none

module lac_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lac_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [lac_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire lac_pkg::req_t                      req_data,
	input  wire logic                               rsp_ready,
	output logic                                    rsp_valid,
	output lac_pkg::rsp_t                           rsp_data,
	input  wire lac_pkg::cmd_t                      cmd,
	output lac_pkg::stat_t                          stat
);
	import lac_pkg::*;

	localparam logic [FW_W-1:0] FW_RESET =
		FW_W'((MAX_FRAME_WIDTH < 256) ? MAX_FRAME_WIDTH : 256);
	localparam logic [FH_W-1:0] FH_RESET =
		FH_W'((MAX_FRAME_HEIGHT < 256) ? MAX_FRAME_HEIGHT : 256);

	// configuration
	logic [FW_W-1:0]    fw_q;
	logic [FH_W-1:0]    fh_q;
	logic [COLOR_W-1:0] bg_q;
	logic [CFG_DIM_W-1:0] cfg_dim;

	assign cfg_dim = cfg_data[CFG_DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_RESET;
			fh_q <= FH_RESET;
			bg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					if (cfg_dim == '0) begin
						fw_q <= FW_W'(1);
					end else if (32'(cfg_dim) > MAX_FRAME_WIDTH) begin
						fw_q <= FW_W'(MAX_FRAME_WIDTH);
					end else begin
						fw_q <= FW_W'(cfg_dim);
					end
				end
				CFG_FRAME_HEIGHT: begin
					if (cfg_dim == '0) begin
						fh_q <= FH_W'(1);
					end else if (32'(cfg_dim) > MAX_FRAME_HEIGHT) begin
						fh_q <= FH_W'(MAX_FRAME_HEIGHT);
					end else begin
						fh_q <= FH_W'(cfg_dim);
					end
				end
				CFG_BACKGROUND: bg_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	req_t req_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
		end
	end

	// eval: layer extent check, frame coordinates, effective alpha
	logic [SURF_W-1:0] sw_sat;
	logic [SURF_W-1:0] sh_sat;
	logic              in_w;
	logic              in_h;
	logic              rw_use;
	logic              rh_use;
	logic              ok_q;
	logic [16:0]       tx_q;
	logic [16:0]       ty_q;
	logic [7:0]        alpha_q;

	always_comb begin
		sw_sat = (32'(req_q.surface_width) > MAX_SURFACE_SIZE) ?
			SURF_W'(MAX_SURFACE_SIZE) : req_q.surface_width;
		sh_sat = (32'(req_q.surface_height) > MAX_SURFACE_SIZE) ?
			SURF_W'(MAX_SURFACE_SIZE) : req_q.surface_height;
		// a positive rect narrower than the surface sets the extent
		rw_use = !req_q.clip_width[15] && (req_q.clip_width != '0) &&
			(req_q.clip_width[15:0] < {5'd0, sw_sat});
		rh_use = !req_q.clip_height[15] && (req_q.clip_height != '0) &&
			(req_q.clip_height[15:0] < {5'd0, sh_sat});
		in_w = (rw_use ? ({6'd0, req_q.pos_x} < req_q.clip_width[15:0]) :
			({1'b0, req_q.pos_x} < sw_sat));
		in_h = (rh_use ? ({6'd0, req_q.pos_y} < req_q.clip_height[15:0]) :
			({1'b0, req_q.pos_y} < sh_sat));
	end

	always_ff @(posedge clk) begin
		ok_q <= req_q.layer_visible && (req_q.surface_width != '0) &&
			(req_q.surface_height != '0) && in_w && in_h;
		tx_q <= {req_q.layer_left[15], req_q.layer_left} + {7'd0, req_q.pos_x};
		ty_q <= {req_q.layer_top[15], req_q.layer_top} + {7'd0, req_q.pos_y};
		alpha_q <= req_q.opaque ? ALPHA_FULL : req_q.pixel_rgba[31:24];
	end

	// lookup: frame bounds and store address
	logic              hit_q;
	logic [ADDR_W-1:0] addr_q;
	logic              blend_hit;
	logic              read_hit;

	always_comb begin
		blend_hit = ok_q && !tx_q[16] && !ty_q[16] &&
			(32'(tx_q[15:0]) < 32'(fw_q)) && (32'(ty_q[15:0]) < 32'(fh_q));
		read_hit = (32'(req_q.pos_x) < 32'(fw_q)) && (32'(req_q.pos_y) < 32'(fh_q));
	end

	always_ff @(posedge clk) begin
		case (req_q.mode)
			MODE_BLEND: begin
				hit_q  <= blend_hit;
				addr_q <= ADDR_W'(32'(ty_q[Y_W-1:0]) * MAX_FRAME_WIDTH +
					32'(tx_q[X_W-1:0]));
			end
			MODE_READ: begin
				hit_q  <= read_hit;
				addr_q <= ADDR_W'(32'(req_q.pos_y[Y_W-1:0]) * MAX_FRAME_WIDTH +
					32'(req_q.pos_x[X_W-1:0]));
			end
			default: begin
				hit_q  <= 1'b0;
				addr_q <= '0;
			end
		endcase
	end

	// clear sweep
	logic [X_W-1:0] cx_q;
	logic [Y_W-1:0] cy_q;
	logic           cx_last;
	logic           cy_last;

	assign cx_last = (32'(cx_q) + 1) == 32'(fw_q);
	assign cy_last = (32'(cy_q) + 1) == 32'(fh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.load) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.clr_step) begin
			if (cx_last) begin
				cx_q <= '0;
				cy_q <= cy_q + Y_W'(1);
			end else begin
				cx_q <= cx_q + X_W'(1);
			end
		end
	end

	// frame store
	logic [COLOR_W-1:0] frame_mem_q [STORE_DEPTH];
	logic [COLOR_W-1:0] rd_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic [COLOR_W-1:0] mixed;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= frame_mem_q[addr_q];
	end

	// mul: per channel products of source and destination weights
	logic [15:0] sp_q [3];
	logic [15:0] dp_q [3];
	logic [7:0]  inv_alpha;

	assign inv_alpha = ALPHA_FULL - alpha_q;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sp_q[c] <= 16'(req_q.pixel_rgba[8*c +: 8]) * 16'(alpha_q);
			dp_q[c] <= 16'(rd_q[8*c +: 8]) * 16'(inv_alpha);
		end
	end

	// finish: divide by 255 as (x + (x >> 8) + 1) >> 8, exact for sums up to 255*255
	logic [16:0] sum [3];
	logic [16:0] quo [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = 17'(sp_q[c]) + 17'(dp_q[c]);
			quo[c] = (sum[c] + (sum[c] >> 8) + 17'd1) >> 8;
			mixed[8*c +: 8] = quo[c][7:0];
		end
	end

	logic blend_write;
	rsp_t rsp_d;

	assign blend_write = cmd.finish && (req_q.mode == MODE_BLEND) && hit_q &&
		(alpha_q != '0);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = mixed;
		if (cmd.clr_step) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(32'(cy_q) * MAX_FRAME_WIDTH + 32'(cx_q));
			mem_wdata = bg_q;
		end else if (blend_write) begin
			mem_we = 1'b1;
			if (alpha_q == ALPHA_FULL) begin
				mem_wdata = req_q.pixel_rgba[COLOR_W-1:0];
			end
		end
	end

	always_comb begin
		rsp_d = '0;
		case (req_q.mode)
			MODE_CLEAR: rsp_d.pixel_drawn = 1'b1;
			MODE_BLEND: rsp_d.pixel_drawn = hit_q && (alpha_q != '0);
			MODE_READ: begin
				rsp_d.pixel_drawn = hit_q;
				rsp_d.read_color  = hit_q ? rd_q : '0;
			end
			default: rsp_d = '0;
		endcase
	end

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign stat.mode     = req_q.mode;
	assign stat.clr_last = cx_last && cy_last;
	assign stat.out_free = !rsp_valid_q || rsp_ready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(rsp_valid_q && !rsp_ready))
		else $error("result overwritten while stalled");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && cmd.finish))
		else $error("clear sweep and blend write in same cycle");

	a_sweep_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> ((32'(cx_q) < 32'(fw_q)) && (32'(cy_q) < 32'(fh_q))))
		else $error("clear sweep outside frame");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q)
		else $error("finished result not presented");

endmodule

`default_nettype wire

[src/layer_alpha_compositor_unit.sv]
// Layer alpha compositor with a frame store of MAX_FRAME_WIDTH x MAX_FRAME_HEIGHT pixels.
// Items come in on req (valid/ready) and one result word per item leaves on rsp.
// Mode clear fills the configured frame with the background color; blend places one
// layer pixel (copy, skip or alpha-over); read returns one frame pixel.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user must write it
// only while idle, which the block does not enforce. The controller takes one item at a
// time. A blend, read or unused-mode item runs evaluate, lookup, store read, multiply and
// finish, where the result is registered; the next item is taken once the controller is
// back in idle. A clear sweeps the frame store one pixel a cycle and then finishes.
// Reset clears the controller, the output valid, the sweep counters and the configuration
// registers (width and height to their maximum up to 256, background black); the frame
// store is not cleared and must be cleared before it is read.
// When rsp is stalled the result word holds in the output register; the next item is
// still accepted and worked up to its finish step, where it waits for the register.
`default_nettype none

module layer_alpha_compositor_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [lac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lac_pkg::CFG_DATA_W-1:0]  cfg_data,
	lac_req_if.sink                              req,
	lac_rsp_if.source                            rsp
);
	import lac_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lac_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire
